// File: src/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst_n is low.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion lbl failed");

// Next-cycle implication, disabled while rst_n is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion lbl failed");

`endif

// File: src/rttpto_pkg.sv
// Types and constants for the RTT estimator / PTO unit.
// No dependencies.
package rttpto_pkg;

    localparam int SAMPLE_W = 32;
    localparam int DELAY_W  = 24;
    localparam int EXP_W    = 5;
    localparam int GRAN_W   = 20;
    localparam int PTO_W    = 36;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 136;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACK_DELAY_EXP = 2'd0,
        CFG_MAX_ACK_DELAY = 2'd1,
        CFG_GRANULARITY   = 2'd2,
        CFG_INITIAL_RTT   = 2'd3
    } cfg_idx_t;

    localparam logic [EXP_W-1:0]    RST_ACK_DELAY_EXP = 5'd3;
    localparam logic [DELAY_W-1:0]  RST_MAX_ACK_DELAY = 24'd25000;
    localparam logic [GRAN_W-1:0]   RST_GRANULARITY   = 20'd1000;
    localparam logic [SAMPLE_W-1:0] RST_INITIAL_RTT   = 32'd333000;

    typedef struct packed {
        logic [EXP_W-1:0]   ack_delay_exp;
        logic [DELAY_W-1:0] delay_cap;
        logic [GRAN_W-1:0]  granularity;
    } cfg_t;

    // One classified request between front and back.
    typedef struct packed {
        logic                is_first;
        logic                space_is_app;
        logic [DELAY_W-1:0]  scaled_delay;
        logic [SAMPLE_W-1:0] rtt_sample;
    } req_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

// File: src/rttpto_queue.sv
// Two-entry request queue between front and back.
// Depends on rttpto_pkg.
module rttpto_queue
    import rttpto_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_req,
    output logic out_valid,
    input  logic out_ready,
    output req_t out_req
);

    localparam int DEPTH = 2;

    req_t       mem_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'(DEPTH));
    assign out_valid = (count_reg != 2'd0);
    assign out_req   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

// File: src/rttpto_front.sv
// Front end: accepts samples, scales and clamps the ack delay, marks the first sample.
// Depends on rttpto_pkg.
module rttpto_front
    import rttpto_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [SAMPLE_W-1:0]  s_sample,
    input  logic [DELAY_W-1:0]   s_raw_delay,
    input  logic                 s_app,
    output hs_t                  q_hs_out,
    input  logic                 q_ready,
    output req_t                 q_req
);

    localparam int SHIFT_W = DELAY_W + SAMPLE_W;

    logic                first_reg, first_next;
    logic                valid_reg, valid_next;
    req_t                req_reg;
    logic [SHIFT_W-1:0]  shifted;
    logic [DELAY_W-1:0]  delay_clamped;
    logic                accept;

    assign s_tready       = !valid_reg || q_ready;
    assign accept         = s_tvalid && s_tready;
    assign q_hs_out.valid = valid_reg;
    assign q_hs_out.ready = s_tready;
    assign q_req          = req_reg;

    always_comb begin
        shifted = {{SAMPLE_W{1'b0}}, s_raw_delay} << cfg.ack_delay_exp;
        if (shifted > {{SAMPLE_W{1'b0}}, cfg.delay_cap}) begin
            delay_clamped = cfg.delay_cap;
        end else begin
            delay_clamped = shifted[DELAY_W-1:0];
        end
        first_next = accept ? 1'b0 : first_reg;
        valid_next = accept || (valid_reg && !q_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
            valid_reg <= 1'b0;
        end else begin
            first_reg <= first_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg.is_first     <= first_reg;
            req_reg.space_is_app <= s_app;
            req_reg.scaled_delay <= delay_clamped;
            req_reg.rtt_sample   <= s_sample;
        end
    end

endmodule

// File: src/rttpto_back.sv
// Back end: updates min, smoothed and variance, then forms the PTO into the output register.
// Depends on rttpto_pkg.
module rttpto_back
    import rttpto_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  req_t                 q_req,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [SAMPLE_W-1:0]  m_smoothed,
    output logic [SAMPLE_W-1:0]  m_variance,
    output logic [SAMPLE_W-1:0]  m_min,
    output logic [PTO_W-1:0]     m_pto
);

    logic [SAMPLE_W-1:0] min_reg, min_next;
    logic [SAMPLE_W-1:0] smoothed_reg, smoothed_next;
    logic [SAMPLE_W-1:0] variance_reg, variance_next;
    logic                st1_valid_reg, st1_valid_next;
    logic                st1_app_reg;
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_smoothed_reg, out_variance_reg, out_min_reg;
    logic [PTO_W-1:0]    out_pto_reg, pto_next;
    logic                st2_ready, pop, st1_move;

    logic [SAMPLE_W:0]   min_plus_delay;
    logic [SAMPLE_W-1:0] sample, adj, diff, min_upd;
    logic [SAMPLE_W+1:0] var3;
    logic [SAMPLE_W+2:0] var_sum, smo7;
    logic [SAMPLE_W+3:0] smo_sum;
    logic [SAMPLE_W+1:0] var4, var_term;

    assign st2_ready = !out_valid_reg || m_ready;
    assign q_ready   = !st1_valid_reg || st2_ready;
    assign pop       = q_valid && q_ready;
    assign st1_move  = st1_valid_reg && st2_ready;

    assign m_valid    = out_valid_reg;
    assign m_smoothed = out_smoothed_reg;
    assign m_variance = out_variance_reg;
    assign m_min      = out_min_reg;
    assign m_pto      = out_pto_reg;

    // Estimator update.
    always_comb begin
        sample         = q_req.rtt_sample;
        min_upd        = (sample < min_reg) ? sample : min_reg;
        min_plus_delay = {1'b0, min_upd}
                       + {{(SAMPLE_W-DELAY_W+1){1'b0}}, q_req.scaled_delay};
        if ({1'b0, sample} >= min_plus_delay) begin
            adj = sample - {{(SAMPLE_W-DELAY_W){1'b0}}, q_req.scaled_delay};
        end else begin
            adj = sample;
        end
        diff    = (smoothed_reg >= adj) ? (smoothed_reg - adj) : (adj - smoothed_reg);
        var3    = {2'b00, variance_reg} + {1'b0, variance_reg, 1'b0};
        var_sum = {1'b0, var3} + {3'b000, diff};
        smo7    = {smoothed_reg, 3'b000} - {3'b000, smoothed_reg};
        smo_sum = {1'b0, smo7} + {4'b0000, adj};

        min_next      = min_reg;
        smoothed_next = smoothed_reg;
        variance_next = variance_reg;
        if (pop) begin
            if (q_req.is_first) begin
                min_next      = sample;
                smoothed_next = sample;
                variance_next = sample >> 1;
            end else begin
                min_next      = min_upd;
                smoothed_next = smo_sum[SAMPLE_W+2:3];
                variance_next = var_sum[SAMPLE_W+1:2];
            end
        end
        st1_valid_next = pop || (st1_valid_reg && !st2_ready);
        out_valid_next = st1_move || (out_valid_reg && !m_ready);
    end

    // PTO from the updated estimates.
    always_comb begin
        var4 = {variance_reg, 2'b00};
        if (var4 < {{(SAMPLE_W+2-GRAN_W){1'b0}}, cfg.granularity}) begin
            var_term = {{(SAMPLE_W+2-GRAN_W){1'b0}}, cfg.granularity};
        end else begin
            var_term = var4;
        end
        pto_next = {4'b0000, smoothed_reg} + {2'b00, var_term}
                 + (st1_app_reg ? {{(PTO_W-DELAY_W){1'b0}}, cfg.delay_cap} : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg       <= '0;
            smoothed_reg  <= RST_INITIAL_RTT;
            variance_reg  <= RST_INITIAL_RTT >> 1;
            st1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            min_reg       <= min_next;
            smoothed_reg  <= smoothed_next;
            variance_reg  <= variance_next;
            st1_valid_reg <= st1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            st1_app_reg <= q_req.space_is_app;
        end
        if (st1_move) begin
            out_smoothed_reg <= smoothed_reg;
            out_variance_reg <= variance_reg;
            out_min_reg      <= min_reg;
            out_pto_reg      <= pto_next;
        end
    end

endmodule

// File: src/rtt_estimator_pto_unit.sv
// QUIC RTT estimator with probe timeout output. Accepts one RTT sample per
// cycle, sustained while m_tready is high; each sample yields one result with
// the updated smoothed RTT, RTT variance, minimum RTT and PTO before backoff.
// From accept to result a sample passes the front register, the queue, the
// estimator update stage and the PTO output register. The rate is set by
// the estimator update, whose min/smoothed/variance recurrence is registered
// in the back end. Configuration writes are taken at any time, one per cycle,
// and are meant to be made while no sample is in flight; initial_rtt writes
// are ignored, reset seeds the estimates and the first sample overwrites them.
// Depends on rttpto_pkg, rttpto_front, rttpto_queue, rttpto_back.
module rtt_estimator_pto_unit
    import rttpto_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,    // rtt_sample[31:0], raw_ack_delay[55:32]
    input  logic                   s_tuser,    // space_is_app
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,    // smoothed_rtt[31:0], rtt_variance[63:32],
                                               // min_rtt[95:64], pto_duration[131:96], zero pad
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t                cfg_reg;
    hs_t                 front_hs;
    req_t                front_req, queue_req;
    logic                queue_in_ready, queue_valid, back_ready;
    logic [SAMPLE_W-1:0] res_smoothed, res_variance, res_min;
    logic [PTO_W-1:0]    res_pto;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ack_delay_exp <= RST_ACK_DELAY_EXP;
            cfg_reg.delay_cap     <= RST_MAX_ACK_DELAY;
            cfg_reg.granularity   <= RST_GRANULARITY;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ACK_DELAY_EXP: cfg_reg.ack_delay_exp <= cfg_data[EXP_W-1:0];
                CFG_MAX_ACK_DELAY: cfg_reg.delay_cap     <= cfg_data[DELAY_W-1:0];
                CFG_GRANULARITY:   cfg_reg.granularity   <= cfg_data[GRAN_W-1:0];
                CFG_INITIAL_RTT:   cfg_reg               <= cfg_reg;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    rttpto_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_sample    (s_tdata[SAMPLE_W-1:0]),
        .s_raw_delay (s_tdata[SAMPLE_W+DELAY_W-1:SAMPLE_W]),
        .s_app       (s_tuser),
        .q_hs_out    (front_hs),
        .q_ready     (queue_in_ready),
        .q_req       (front_req)
    );

    rttpto_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_hs.valid),
        .in_ready  (queue_in_ready),
        .in_req    (front_req),
        .out_valid (queue_valid),
        .out_ready (back_ready),
        .out_req   (queue_req)
    );

    rttpto_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .q_valid    (queue_valid),
        .q_ready    (back_ready),
        .q_req      (queue_req),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_smoothed (res_smoothed),
        .m_variance (res_variance),
        .m_min      (res_min),
        .m_pto      (res_pto)
    );

    assign m_tdata = {{(M_TDATA_W-3*SAMPLE_W-PTO_W){1'b0}},
                      res_pto, res_min, res_variance, res_smoothed};

endmodule

// File: src/rttpto_checker.sv
// Port-level checks on the RTT estimator / PTO unit, bound to the top level.
// Depends on rttpto_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rttpto_checker
    import rttpto_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [SAMPLE_W-1:0] smoothed, variance;
    logic [PTO_W-1:0]    pto;

    assign smoothed = m_tdata[SAMPLE_W-1:0];
    assign variance = m_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign pto      = m_tdata[3*SAMPLE_W+PTO_W-1:3*SAMPLE_W];

    `ASSERT_NEXT(a_reset_clears_out, aclk, 1'b1, !aresetn, !m_tvalid)
    `ASSERT_NEXT(a_out_held, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    `ASSERT_SAME(a_pto_over_smoothed, aclk, aresetn, m_tvalid, pto >= {4'b0000, smoothed})
    `ASSERT_SAME(a_pto_over_var4, aclk, aresetn, m_tvalid, pto >= {2'b00, variance, 2'b00})

endmodule

bind rtt_estimator_pto_unit rttpto_checker u_rttpto_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
